// ===== sv/triangle_tangent_vectors_defines.svh =====
// Assertion macros shared by the block's RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef TRIANGLE_TANGENT_VECTORS_DEFINES_SVH
`define TRIANGLE_TANGENT_VECTORS_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TTV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ttv: property violated");
`define TTV_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ttv: forbidden condition seen");
`else
`define TTV_ASSERT(label, prop)
`define TTV_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== sv/ttv_pkg.sv =====
package ttv_pkg;

  localparam int IDX_W   = 16;
  localparam int VAL_W   = 32;
  localparam int DELTA_W = VAL_W + 1;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int MAG_W   = SUM_W - 1;
  localparam int QUO_W   = VAL_W;
  localparam int STEP_W  = $clog2(QUO_W + 1);
  localparam int AXES    = 3;
  localparam int MUL_OPS = 2 + 2 * AXES;
  localparam int MCNT_W  = $clog2(MUL_OPS);

  localparam int DEF_INDEX_BITS    = 16;
  localparam int DEF_FRACTION_BITS = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } ttv_state_e;

  // Tag travelling alongside a request through the multiplier
  typedef struct packed {
    logic              vld;
    logic              sub;
    logic [MCNT_W-1:0] tag;
  } ttv_mul_ctl_t;

  typedef struct packed {
    logic go;
    logic neg;
  } ttv_div_ctl_t;

endpackage

// ===== sv/ttv_corner_if.sv =====
interface ttv_corner_if;
  logic                               valid;
  logic                               ready;
  logic        [ttv_pkg::IDX_W-1:0]   vertex_index;
  logic signed [ttv_pkg::VAL_W-1:0]   pos_x;
  logic signed [ttv_pkg::VAL_W-1:0]   pos_y;
  logic signed [ttv_pkg::VAL_W-1:0]   pos_z;
  logic signed [ttv_pkg::VAL_W-1:0]   tex_u;
  logic signed [ttv_pkg::VAL_W-1:0]   tex_v;

  modport source (
    output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
    output ready
  );
endinterface

// ===== sv/ttv_tangent_if.sv =====
interface ttv_tangent_if;
  logic                               valid;
  logic                               ready;
  logic        [ttv_pkg::IDX_W-1:0]   target_index;
  logic signed [ttv_pkg::VAL_W-1:0]   tangent_x;
  logic signed [ttv_pkg::VAL_W-1:0]   tangent_y;
  logic signed [ttv_pkg::VAL_W-1:0]   tangent_z;
  logic                               degenerate;
  logic                               last_of_triangle;

  modport source (
    output valid, target_index, tangent_x, tangent_y, tangent_z, degenerate,
           last_of_triangle,
    input  ready
  );
  modport sink (
    input  valid, target_index, tangent_x, tangent_y, tangent_z, degenerate,
           last_of_triangle,
    output ready
  );
endinterface

// ===== sv/ttv_mul.sv =====
module ttv_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ttv_pkg::ttv_mul_ctl_t               ctl_i,
  input  logic signed [ttv_pkg::DELTA_W-1:0]  a_i,
  input  logic signed [ttv_pkg::DELTA_W-1:0]  b_i,
  output ttv_pkg::ttv_mul_ctl_t               ctl_o,
  output logic signed [ttv_pkg::SUM_W-1:0]    term_o
);
  import ttv_pkg::*;

  logic signed [DELTA_W-1:0] neg_a, neg_b;
  logic        [VAL_W-1:0]   mag_a, mag_b;
  logic        [PROD_W-1:0]  prod_q;
  logic                      sign_q;
  ttv_mul_ctl_t              ctl_q;
  logic signed [SUM_W-1:0]   prod_ext;

  // A difference of two 32-bit values has a magnitude that fits in 32 bits
  always_comb begin
    neg_a = -a_i;
    neg_b = -b_i;
    mag_a = a_i[DELTA_W-1] ? neg_a[VAL_W-1:0] : a_i[VAL_W-1:0];
    mag_b = b_i[DELTA_W-1] ? neg_b[VAL_W-1:0] : b_i[VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= mag_a * mag_b;
      sign_q <= a_i[DELTA_W-1] ^ b_i[DELTA_W-1] ^ ctl_i.sub;
    end
  end

  always_comb begin
    prod_ext = $signed({{(SUM_W-PROD_W){1'b0}}, prod_q});
    term_o   = sign_q ? -prod_ext : prod_ext;
  end

  assign ctl_o = ctl_q;

endmodule

// ===== sv/ttv_div.sv =====
module ttv_div #(
  parameter int FRACTION_BITS = ttv_pkg::DEF_FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttv_pkg::ttv_div_ctl_t       ctl_i,
  input  logic [ttv_pkg::MAG_W-1:0]   num_mag_i,
  input  logic [ttv_pkg::MAG_W-1:0]   den_mag_i,
  output logic                        done_o,
  output logic [ttv_pkg::VAL_W-1:0]   quot_o
);
  import ttv_pkg::*;

  localparam int DivW = MAG_W + QUO_W;

  logic [DivW-1:0]   rem_q, rem_d, dsh_q, dsh_d, diff;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d, done_q, done_d, neg_q, neg_d, ge;
  logic [VAL_W-1:0]  res_q, res_d;

  // Clamp the magnitude quotient into a signed result word
  function automatic logic [VAL_W-1:0] sat_word(logic neg, logic ovf,
                                                logic [QUO_W-1:0] q);
    logic [VAL_W-1:0] r;
    if (neg) begin
      if (ovf || (q[QUO_W-1] && (|q[QUO_W-2:0]))) r = {1'b1, {(VAL_W-1){1'b0}}};
      else r = -q;
    end else begin
      if (ovf || q[QUO_W-1]) r = {1'b0, {(VAL_W-1){1'b1}}};
      else r = q;
    end
    return r;
  endfunction

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    ge     = rem_q >= dsh_q;
    diff   = rem_q - dsh_q;
    if (ctl_i.go) begin
      rem_d  = DivW'(num_mag_i) << FRACTION_BITS;
      dsh_d  = DivW'(den_mag_i) << QUO_W;
      quo_d  = '0;
      step_d = STEP_W'(QUO_W);
      busy_d = 1'b1;
      neg_d  = ctl_i.neg;
    end else if (busy_q) begin
      dsh_d = dsh_q >> 1;
      if (step_q == STEP_W'(QUO_W)) begin
        // first step only checks whether the quotient overflows the word
        if (ge) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = sat_word(neg_q, 1'b1, quo_q);
        end else begin
          step_d = step_q - 1'b1;
        end
      end else begin
        if (ge) rem_d = diff;
        quo_d = {quo_q[QUO_W-2:0], ge};
        if (step_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = sat_word(neg_q, 1'b0, quo_d);
        end else begin
          step_d = step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

// ===== sv/triangle_tangent_vectors.sv =====
// Per-triangle tangent from position and texture deltas. Corners of a triangle
// list arrive one request at a time (index, position and UV in signed fixed
// point with FRACTION_BITS fraction bits). The first two corners of each
// triangle are held. The third corner starts the computation: eight 32x32
// products on one shared multiplier form the UV determinant and the three
// numerators, then one shared restoring divider works each axis in turn, one
// quotient bit a cycle (it exits after its first step when the quotient needs
// more than 32 bits). Three results, for corners 0, 1 and 2, follow in order,
// the last flagged. When the determinant is zero there is no division; the
// results carry zero tangents and the degenerate flag. The block takes no new
// corner between the third corner and the hand-over of the third result.
`include "triangle_tangent_vectors_defines.svh"

module triangle_tangent_vectors #(
  parameter int INDEX_BITS    = ttv_pkg::DEF_INDEX_BITS,
  parameter int FRACTION_BITS = ttv_pkg::DEF_FRACTION_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttv_corner_if.sink   corner_i,
  ttv_tangent_if.source tangent_o
);
  import ttv_pkg::*;

  localparam int HeldW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;

  // Sequencer state
  ttv_state_e        state_q, state_d;
  logic [1:0]        count_q, count_d;
  logic [MCNT_W-1:0] mcnt_q, mcnt_d;
  logic              mrun_q, mrun_d;
  logic [1:0]        axis_q, axis_d;
  logic              drun_q, drun_d;
  logic [1:0]        emit_q, emit_d;

  // Held corners and deltas
  logic        [HeldW-1:0]   held_idx_q [3];
  logic signed [VAL_W-1:0]   pos_q      [2][AXES];
  logic signed [VAL_W-1:0]   tu_q       [2];
  logic signed [VAL_W-1:0]   tv_q       [2];
  logic signed [DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DELTA_W-1:0] dp1_q [AXES];
  logic signed [DELTA_W-1:0] dp2_q [AXES];

  // Accumulated products and results
  logic signed [SUM_W-1:0] part_q, det_q;
  logic signed [SUM_W-1:0] num_q [AXES];
  logic        [VAL_W-1:0] tan_q [AXES];

  logic                      acc_in, acc_out, degen, tan_clr, last_prod;
  logic signed [DELTA_W-1:0] mul_a, mul_b;
  ttv_mul_ctl_t              mul_ctl, mul_ctl_out;
  logic signed [SUM_W-1:0]   mul_term, num_sel, num_neg, det_neg;
  ttv_div_ctl_t              div_ctl;
  logic [MAG_W-1:0]          num_mag, den_mag;
  logic                      div_done;
  logic [VAL_W-1:0]          div_quot;

  assign corner_i.ready = (state_q == ST_IDLE);
  assign acc_in         = corner_i.valid && corner_i.ready;
  assign acc_out        = tangent_o.valid && tangent_o.ready;
  assign degen          = (det_q == '0);
  assign last_prod      = mul_ctl_out.vld && (mul_ctl_out.tag == MCNT_W'(MUL_OPS - 1));

  // ---------------------------------------------------------------------------
  // Corner capture: hold corners 0 and 1, form all deltas on corner 2
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      held_idx_q[count_q] <= corner_i.vertex_index[HeldW-1:0];
      if (count_q < 2'd2) begin
        pos_q[count_q[0]][0] <= corner_i.pos_x;
        pos_q[count_q[0]][1] <= corner_i.pos_y;
        pos_q[count_q[0]][2] <= corner_i.pos_z;
        tu_q[count_q[0]]     <= corner_i.tex_u;
        tv_q[count_q[0]]     <= corner_i.tex_v;
      end else begin
        du1_q    <= DELTA_W'(tu_q[1]) - DELTA_W'(tu_q[0]);
        dv1_q    <= DELTA_W'(tv_q[1]) - DELTA_W'(tv_q[0]);
        du2_q    <= DELTA_W'(corner_i.tex_u) - DELTA_W'(tu_q[0]);
        dv2_q    <= DELTA_W'(corner_i.tex_v) - DELTA_W'(tv_q[0]);
        dp1_q[0] <= DELTA_W'(pos_q[1][0]) - DELTA_W'(pos_q[0][0]);
        dp1_q[1] <= DELTA_W'(pos_q[1][1]) - DELTA_W'(pos_q[0][1]);
        dp1_q[2] <= DELTA_W'(pos_q[1][2]) - DELTA_W'(pos_q[0][2]);
        dp2_q[0] <= DELTA_W'(corner_i.pos_x) - DELTA_W'(pos_q[0][0]);
        dp2_q[1] <= DELTA_W'(corner_i.pos_y) - DELTA_W'(pos_q[0][1]);
        dp2_q[2] <= DELTA_W'(corner_i.pos_z) - DELTA_W'(pos_q[0][2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Multiplier schedule: even steps open a sum, odd steps subtract into it.
  //   det = du1*dv2 - dv1*du2,  num[a] = dp1[a]*dv2 - dp2[a]*dv1
  // ---------------------------------------------------------------------------
  always_comb begin
    case (mcnt_q)
      3'd0:    begin mul_a = du1_q;    mul_b = dv2_q; end
      3'd1:    begin mul_a = dv1_q;    mul_b = du2_q; end
      3'd2:    begin mul_a = dp1_q[0]; mul_b = dv2_q; end
      3'd3:    begin mul_a = dp2_q[0]; mul_b = dv1_q; end
      3'd4:    begin mul_a = dp1_q[1]; mul_b = dv2_q; end
      3'd5:    begin mul_a = dp2_q[1]; mul_b = dv1_q; end
      3'd6:    begin mul_a = dp1_q[2]; mul_b = dv2_q; end
      default: begin mul_a = dp2_q[2]; mul_b = dv1_q; end
    endcase
    mul_ctl.vld = (state_q == ST_MUL) && mrun_q;
    mul_ctl.sub = mcnt_q[0];
    mul_ctl.tag = mcnt_q;
  end

  ttv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctl_o  (mul_ctl_out),
    .term_o (mul_term)
  );

  always_ff @(posedge clk_i) begin
    if (mul_ctl_out.vld) begin
      if (!mul_ctl_out.tag[0]) begin
        part_q <= mul_term;
      end else begin
        case (mul_ctl_out.tag[2:1])
          2'd0:    det_q    <= part_q + mul_term;
          2'd1:    num_q[0] <= part_q + mul_term;
          2'd2:    num_q[1] <= part_q + mul_term;
          default: num_q[2] <= part_q + mul_term;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider operands: magnitudes of the selected numerator and the determinant
  // ---------------------------------------------------------------------------
  always_comb begin
    num_sel = num_q[axis_q];
    num_neg = -num_sel;
    det_neg = -det_q;
    num_mag = num_sel[SUM_W-1] ? num_neg[MAG_W-1:0] : num_sel[MAG_W-1:0];
    den_mag = det_q[SUM_W-1] ? det_neg[MAG_W-1:0] : det_q[MAG_W-1:0];
  end

  ttv_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_ctl),
    .num_mag_i (num_mag),
    .den_mag_i (den_mag),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mcnt_d      = mcnt_q;
    mrun_d      = mrun_q;
    axis_d      = axis_q;
    drun_d      = drun_q;
    emit_d      = emit_q;
    div_ctl.go  = 1'b0;
    div_ctl.neg = num_sel[SUM_W-1] ^ det_q[SUM_W-1];
    tan_clr     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          if (count_q < 2'd2) begin
            count_d = count_q + 1'b1;
          end else begin
            count_d = '0;
            mcnt_d  = '0;
            mrun_d  = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // issue one product a cycle, then wait for the last one to land
        if (mrun_q) begin
          if (mcnt_q == MCNT_W'(MUL_OPS - 1)) mrun_d = 1'b0;
          else mcnt_d = mcnt_q + 1'b1;
        end
        if (last_prod) begin
          axis_d = '0;
          drun_d = 1'b0;
          emit_d = '0;
          if (degen) begin
            tan_clr = 1'b1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!drun_q) begin
          div_ctl.go = 1'b1;
          drun_d     = 1'b1;
        end else if (div_done) begin
          drun_d = 1'b0;
          if (axis_q == 2'(AXES - 1)) state_d = ST_EMIT;
          else axis_d = axis_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (acc_out) begin
          if (emit_q == 2'd2) begin
            emit_d  = '0;
            state_d = ST_IDLE;
          end else begin
            emit_d = emit_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mcnt_q  <= '0;
      mrun_q  <= 1'b0;
      axis_q  <= '0;
      drun_q  <= 1'b0;
      emit_q  <= '0;
    end else begin
      count_q <= count_d;
      mcnt_q  <= mcnt_d;
      mrun_q  <= mrun_d;
      axis_q  <= axis_d;
      drun_q  <= drun_d;
      emit_q  <= emit_d;
    end
  end

  // Hold each axis result as the divider finishes; zero them all when degenerate
  always_ff @(posedge clk_i) begin
    if (tan_clr) begin
      tan_q[0] <= '0;
      tan_q[1] <= '0;
      tan_q[2] <= '0;
    end else if (div_done && (state_q == ST_DIV)) begin
      tan_q[axis_q] <= div_quot;
    end
  end

  // ---------------------------------------------------------------------------
  // Result port: three requests per triangle from the held results
  // ---------------------------------------------------------------------------
  assign tangent_o.valid            = (state_q == ST_EMIT);
  assign tangent_o.target_index     = IDX_W'(held_idx_q[emit_q]);
  assign tangent_o.tangent_x        = tan_q[0];
  assign tangent_o.tangent_y        = tan_q[1];
  assign tangent_o.tangent_z        = tan_q[2];
  assign tangent_o.degenerate       = degen;
  assign tangent_o.last_of_triangle = (emit_q == 2'd2);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TTV_ASSERT_NEVER(a_in_out_exclusive, corner_i.ready && tangent_o.valid)
  `TTV_ASSERT(a_third_starts_mul, acc_in && (count_q == 2'd2) |=> state_q == ST_MUL)
  `TTV_ASSERT_NEVER(a_degen_zero, tangent_o.valid && degen && |(tan_q[0] | tan_q[1] | tan_q[2]))
  `TTV_ASSERT(a_last_frees_input, acc_out && tangent_o.last_of_triangle |=> corner_i.ready)

endmodule
